/* hw/rtl/sbsr_pkg.sv */
// ----------------------------------------------------------------------------
// sbsr_pkg: shared types and constants
// Field widths, matrix/viewport slot layout, fixed-point constants and the
// small helpers used by the front end, the corner engine and the top level.
// ----------------------------------------------------------------------------
package sbsr_pkg;

  localparam int COORD_BITS = 16;
  localparam int COEF_BITS  = 16;
  localparam int CBITS      = (COEF_BITS < 16) ? COEF_BITS : 16;

  // product and clip widths
  localparam int PROD_BITS  = COORD_BITS + CBITS;
  localparam int CLIP_BITS  = PROD_BITS + 2;
  localparam int NUM_BITS   = CLIP_BITS + 1;
  localparam int DEN_BITS   = CLIP_BITS + 1;

  localparam int FRAC_BITS  = 17;
  localparam logic [FRAC_BITS-1:0] FRAC_ONE = FRAC_BITS'(65536);

  // divider depth and the engine's issue-to-result latency
  localparam int DIV_ST = 16;
  localparam int LAT    = 3 + 1 + DIV_ST + 1;

  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DAT_BITS = 64;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ROW0   = 3'd0,
    REG_ROW1   = 3'd1,
    REG_ROW2   = 3'd2,
    REG_ROW3   = 3'd3,
    REG_CAM    = 3'd4,
    REG_VIEW   = 3'd5
  } reg_idx_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [CBITS-1:0]      coef_t;
  typedef logic signed [CLIP_BITS-1:0]  clip_t;

  // one queued light: its box corners' bounds, or an early full-view flag
  typedef struct packed {
    logic   full;
    coord_t lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  } job_t;

  typedef struct packed {
    logic [13:0] vx, vy, vw, vh;
  } view_t;

  function automatic coord_t sat_coord(input logic signed [17:0] v);
    logic signed [17:0] hi;
    logic signed [17:0] lo;
    hi = 18'sd0;
    lo = 18'sd0;
    if (COORD_BITS >= 18) begin
      return coord_t'(v);
    end
    hi = (18'sd1 <<< (COORD_BITS - 1)) - 18'sd1;
    lo = -hi - 18'sd1;
    if (v > hi) return coord_t'(hi);
    if (v < lo) return coord_t'(lo);
    return coord_t'(v);
  endfunction

endpackage

/* hw/rtl/sbsr_if.sv */
// ----------------------------------------------------------------------------
// sbsr_if: valid/ready channel
// Generic stream interface carrying a payload of type T.
// ----------------------------------------------------------------------------
interface sbsr_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/sbsr_light_in_t.sv */
// ----------------------------------------------------------------------------
// sbsr_chan_pkg: channel payload types
// Payload structs of the light, rectangle and configuration channels.
// ----------------------------------------------------------------------------
package sbsr_chan_pkg;
  typedef struct packed {
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;
    logic [15:0]        radius;
  } light_t;

  typedef struct packed {
    logic [14:0] rect_x;
    logic [14:0] rect_y;
    logic [13:0] rect_w;
    logic [13:0] rect_h;
    logic        full_view;
  } rect_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [63:0] wdata;
  } cfg_t;
endpackage

/* hw/rtl/sbsr_front.sv */
// ----------------------------------------------------------------------------
// sbsr_front: light classifier
// Two-stage pipe: squares of distance and radius, then compare and box bounds.
// ----------------------------------------------------------------------------
module sbsr_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [47:0]            cam_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [15:0]     lx_i,
  input  logic signed [15:0]     ly_i,
  input  logic signed [15:0]     lz_i,
  input  logic [15:0]            rad_i,
  output logic                   job_valid_o,
  input  logic                   job_ready_i,
  output sbsr_pkg::job_t         job_o
);
  import sbsr_pkg::*;

  logic              s1_valid_q, s2_valid_q;
  logic              s1_go, s2_go;
  logic signed [16:0] dx, dy, dz;
  logic [33:0]       sqx_q, sqy_q, sqz_q, rr_q;
  logic signed [15:0] cx_q, cy_q, cz_q;
  logic [15:0]       r_q;
  job_t              job_q;
  logic [35:0]       dist2;

  assign s2_go      = !s2_valid_q || job_ready_i;
  assign s1_go      = !s1_valid_q || s2_go;
  assign in_ready_o = s1_go;

  assign dx = 17'(signed'(cam_i[15:0]))  - 17'(lx_i);
  assign dy = 17'(signed'(cam_i[31:16])) - 17'(ly_i);
  assign dz = 17'(signed'(cam_i[47:32])) - 17'(lz_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_go) s1_valid_q <= in_valid_i;
      if (s2_go) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && in_valid_i) begin
      sqx_q <= 34'(dx * dx);
      sqy_q <= 34'(dy * dy);
      sqz_q <= 34'(dz * dz);
      rr_q  <= 34'(rad_i * rad_i);
      cx_q  <= lx_i;
      cy_q  <= ly_i;
      cz_q  <= lz_i;
      r_q   <= rad_i;
    end
  end

  assign dist2 = 36'(sqx_q) + 36'(sqy_q) + 36'(sqz_q);

  always_ff @(posedge clk_i) begin
    if (s2_go && s1_valid_q) begin
      job_q.full <= (dist2 <= 36'(rr_q));
      job_q.lo_x <= sat_coord(18'(cx_q) - 18'(signed'({1'b0, r_q})));
      job_q.hi_x <= sat_coord(18'(cx_q) + 18'(signed'({1'b0, r_q})));
      job_q.lo_y <= sat_coord(18'(cy_q) - 18'(signed'({1'b0, r_q})));
      job_q.hi_y <= sat_coord(18'(cy_q) + 18'(signed'({1'b0, r_q})));
      job_q.lo_z <= sat_coord(18'(cz_q) - 18'(signed'({1'b0, r_q})));
      job_q.hi_z <= sat_coord(18'(cz_q) + 18'(signed'({1'b0, r_q})));
    end
  end

  assign job_valid_o = s2_valid_q;
  assign job_o       = job_q;
endmodule

/* hw/rtl/sbsr_fifo.sv */
// ----------------------------------------------------------------------------
// sbsr_fifo: job queue
// Two-entry queue decoupling the classifier from the corner engine.
// ----------------------------------------------------------------------------
module sbsr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  sbsr_pkg::job_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output sbsr_pkg::job_t rd_data_o
);
  import sbsr_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

/* hw/rtl/sbsr_back.sv */
// ----------------------------------------------------------------------------
// sbsr_back: corner engine
// Issues one box corner per cycle while no earlier job is pending, into a
// pipelined transform and 16-step divider, tracks min/max fractions, scales.
// ----------------------------------------------------------------------------
module sbsr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [63:0]    row_i [4],
  input  sbsr_pkg::view_t view_i,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  sbsr_pkg::job_t job_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [14:0]    rect_x_o,
  output logic [14:0]    rect_y_o,
  output logic [13:0]    rect_w_o,
  output logic [13:0]    rect_h_o,
  output logic           full_o
);
  import sbsr_pkg::*;

  // issue: corner counter over the job at the queue head
  logic [3:0] k_q;
  logic       busy;
  logic       issue;
  logic       last;
  logic       acc_busy_q;
  logic       fin_valid_q;

  // accumulation and finishing
  logic [FRAC_BITS-1:0] minx_q, maxx_q, miny_q, maxy_q;
  logic                 full_q;
  logic [4:0]           pend_q;

  assign busy = job_valid_i && !acc_busy_q;
  assign issue = busy && !job_i.full;
  assign last  = job_i.full || (k_q == 4'd7);
  assign job_ready_o = busy && last;

  // stage 0: corner coordinates
  coord_t px_q, py_q, pz_q;
  logic   v0_q, l0_q;
  // stage 1: products
  logic signed [PROD_BITS-1:0] pr_q [4][4];
  logic   v1_q, l1_q;
  // stage 2: clip sums
  clip_t  cx_q, cy_q, cw_q;
  logic   v2_q, l2_q;
  // stage 3: numerators and divisor set-up
  logic [NUM_BITS-1:0]  rem_q [DIV_ST+1];
  logic [DEN_BITS-1:0]  den_q [DIV_ST+1];
  logic [NUM_BITS-1:0]  remy_q [DIV_ST+1];
  logic [15:0]          qx_q [DIV_ST+1];
  logic [15:0]          qy_q [DIV_ST+1];
  logic [1:0]           satx_q [DIV_ST+1];
  logic [1:0]           saty_q [DIV_ST+1];
  logic                 bad_q [DIV_ST+1];
  logic                 dv_q [DIV_ST+1];
  logic                 dl_q [DIV_ST+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= 4'd0;
    end else if (issue) begin
      k_q <= (k_q == 4'd7) ? 4'd0 : k_q + 4'd1;
    end
  end

  function automatic coef_t cf(input logic [63:0] r, input int c);
    return coef_t'(r[16*c +: CBITS]);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      l0_q <= 1'b0;
      l1_q <= 1'b0;
      l2_q <= 1'b0;
    end else begin
      v0_q <= issue;
      l0_q <= issue && last;
      v1_q <= v0_q;
      l1_q <= l0_q;
      v2_q <= v1_q;
      l2_q <= l1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= k_q[0] ? job_i.hi_x : job_i.lo_x;
    py_q <= k_q[1] ? job_i.hi_y : job_i.lo_y;
    pz_q <= k_q[2] ? job_i.hi_z : job_i.lo_z;
    for (int r = 0; r < 4; r++) begin
      if (r != 2) begin
        pr_q[r][0] <= PROD_BITS'(cf(row_i[r], 0) * px_q);
        pr_q[r][1] <= PROD_BITS'(cf(row_i[r], 1) * py_q);
        pr_q[r][2] <= PROD_BITS'(cf(row_i[r], 2) * pz_q);
        pr_q[r][3] <= PROD_BITS'(cf(row_i[r], 3) * coord_t'(256));
      end else begin
        for (int c = 0; c < 4; c++) pr_q[r][c] <= '0;
      end
    end
    cx_q <= CLIP_BITS'(pr_q[0][0]) + CLIP_BITS'(pr_q[0][1])
          + CLIP_BITS'(pr_q[0][2]) + CLIP_BITS'(pr_q[0][3]);
    cy_q <= CLIP_BITS'(pr_q[1][0]) + CLIP_BITS'(pr_q[1][1])
          + CLIP_BITS'(pr_q[1][2]) + CLIP_BITS'(pr_q[1][3]);
    cw_q <= CLIP_BITS'(pr_q[3][0]) + CLIP_BITS'(pr_q[3][1])
          + CLIP_BITS'(pr_q[3][2]) + CLIP_BITS'(pr_q[3][3]);
  end

  // divider set-up: numerators n = w - x and y + w, divisor 2w
  logic signed [NUM_BITS-1:0] nx, ny;
  logic [DEN_BITS-1:0]        d2;
  assign nx = NUM_BITS'(cw_q) - NUM_BITS'(cx_q);
  assign ny = NUM_BITS'(cy_q) + NUM_BITS'(cw_q);
  assign d2 = DEN_BITS'(cw_q) <<< 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= DIV_ST; s++) begin
        dv_q[s] <= 1'b0;
        dl_q[s] <= 1'b0;
      end
    end else begin
      dv_q[0] <= v2_q;
      dl_q[0] <= l2_q;
      for (int s = 1; s <= DIV_ST; s++) begin
        dv_q[s] <= dv_q[s-1];
        dl_q[s] <= dl_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // sat: bit1 = zero, bit0 = one
    bad_q[0]  <= (cw_q <= 0);
    den_q[0]  <= d2;
    rem_q[0]  <= NUM_BITS'(nx);
    remy_q[0] <= NUM_BITS'(ny);
    qx_q[0]   <= '0;
    qy_q[0]   <= '0;
    satx_q[0] <= {nx <= 0, (nx > 0) && (NUM_BITS'(nx) >= NUM_BITS'(d2))};
    saty_q[0] <= {ny <= 0, (ny > 0) && (NUM_BITS'(ny) >= NUM_BITS'(d2))};
    for (int s = 1; s <= DIV_ST; s++) begin
      logic [NUM_BITS:0] tx, ty;
      tx = {rem_q[s-1], 1'b0};
      ty = {remy_q[s-1], 1'b0};
      den_q[s]  <= den_q[s-1];
      bad_q[s]  <= bad_q[s-1];
      satx_q[s] <= satx_q[s-1];
      saty_q[s] <= saty_q[s-1];
      if (tx >= (NUM_BITS+1)'(den_q[s-1])) begin
        rem_q[s] <= NUM_BITS'(tx - (NUM_BITS+1)'(den_q[s-1]));
        qx_q[s]  <= {qx_q[s-1][14:0], 1'b1};
      end else begin
        rem_q[s] <= NUM_BITS'(tx);
        qx_q[s]  <= {qx_q[s-1][14:0], 1'b0};
      end
      if (ty >= (NUM_BITS+1)'(den_q[s-1])) begin
        remy_q[s] <= NUM_BITS'(ty - (NUM_BITS+1)'(den_q[s-1]));
        qy_q[s]   <= {qy_q[s-1][14:0], 1'b1};
      end else begin
        remy_q[s] <= NUM_BITS'(ty);
        qy_q[s]   <= {qy_q[s-1][14:0], 1'b0};
      end
    end
  end

  logic [FRAC_BITS-1:0] fx, fy;
  assign fx = satx_q[DIV_ST][1] ? '0 : satx_q[DIV_ST][0] ? FRAC_ONE
            : FRAC_BITS'(qx_q[DIV_ST]);
  assign fy = saty_q[DIV_ST][1] ? '0 : saty_q[DIV_ST][0] ? FRAC_ONE
            : FRAC_BITS'(qy_q[DIV_ST]);

  // a full-view job takes the short path: it skips the pipe
  logic short_go;
  assign short_go = busy && job_i.full;

  // acc_busy_q: a job is done issuing; hold issue until its result is taken
  logic fin_take;
  assign fin_take = fin_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_busy_q  <= 1'b0;
      fin_valid_q <= 1'b0;
      minx_q <= FRAC_ONE;
      miny_q <= FRAC_ONE;
      maxx_q <= '0;
      maxy_q <= '0;
      full_q <= 1'b0;
      pend_q <= '0;
    end else begin
      if (fin_take) fin_valid_q <= 1'b0;
      if (short_go) begin
        acc_busy_q <= 1'b1;
        full_q     <= 1'b1;
        pend_q     <= 5'(LAT);
      end else if (issue && last) begin
        acc_busy_q <= 1'b1;
      end
      if (acc_busy_q && pend_q != '0) pend_q <= pend_q - 5'd1;
      if (dv_q[DIV_ST]) begin
        if (bad_q[DIV_ST]) full_q <= 1'b1;
        if (fx < minx_q) minx_q <= fx;
        if (fx > maxx_q) maxx_q <= fx;
        if (fy < miny_q) miny_q <= fy;
        if (fy > maxy_q) maxy_q <= fy;
      end
      if (acc_busy_q && !fin_valid_q
          && ((dv_q[DIV_ST] && dl_q[DIV_ST]) || (full_q && pend_q == 5'd1))) begin
        fin_valid_q <= 1'b1;
      end
      if (fin_take) begin
        acc_busy_q <= 1'b0;
        minx_q <= FRAC_ONE;
        miny_q <= FRAC_ONE;
        maxx_q <= '0;
        maxy_q <= '0;
        full_q <= 1'b0;
        pend_q <= '0;
      end
    end
  end

  // result registers: mins/maxes after last corner fold, computed on read
  logic [FRAC_BITS-1:0] ax, ay, bx, by;
  logic                 ff;
  logic                 lastfold;
  assign lastfold = dv_q[DIV_ST] && dl_q[DIV_ST];
  assign ax = (lastfold && fx < minx_q) ? fx : minx_q;
  assign bx = (lastfold && fx > maxx_q) ? fx : maxx_q;
  assign ay = (lastfold && fy < miny_q) ? fy : miny_q;
  assign by = (lastfold && fy > maxy_q) ? fy : maxy_q;
  assign ff = full_q || (lastfold && bad_q[DIV_ST]);

  logic [FRAC_BITS-1:0] rminx_q, rmaxx_q, rminy_q, rmaxy_q;
  logic                 rfull_q;
  logic [30:0]          pxm, pym, pwm, phm;

  always_ff @(posedge clk_i) begin
    if (acc_busy_q && !fin_valid_q) begin
      rminx_q <= ax;
      rmaxx_q <= bx;
      rminy_q <= ay;
      rmaxy_q <= by;
      rfull_q <= ff;
    end
  end

  assign pxm = 31'(view_i.vw) * 31'(rminx_q);
  assign pym = 31'(view_i.vh) * 31'(rminy_q);
  assign pwm = 31'(view_i.vw) * 31'(rmaxx_q - rminx_q);
  assign phm = 31'(view_i.vh) * 31'(rmaxy_q - rminy_q);

  assign out_valid_o = fin_valid_q;
  assign full_o      = rfull_q;
  assign rect_x_o = rfull_q ? 15'(view_i.vx) : 15'(view_i.vx) + 15'(pxm[30:16]);
  assign rect_y_o = rfull_q ? 15'(view_i.vy) : 15'(view_i.vy) + 15'(pym[30:16]);
  assign rect_w_o = rfull_q ? view_i.vw : pwm[29:16];
  assign rect_h_o = rfull_q ? view_i.vh : phm[29:16];
endmodule

/* hw/rtl/sphere_box_scissor_rect.sv */
// ----------------------------------------------------------------------------
// sphere_box_scissor_rect: light scissor rectangle
// Screen-space scissor rectangle of a spherical light from its bounding box.
// ----------------------------------------------------------------------------
// One light beat in gives one rectangle beat out. A two-stage classifier
// tests the camera against the sphere and forms the box bounds; a two-entry
// queue feeds the corner engine, which issues one of the 8 box corners per
// cycle, while it is not busy with an earlier light, into a 3-stage matrix
// transform and a 16-stage divider (one quotient bit per stage). The engine
// handles one light at a time, until its result has been taken.
// A light with the camera inside the sphere skips the transform. The user
// must write configuration only while idle; the block does not enforce it.
module sphere_box_scissor_rect (
  input  logic clk_i,
  input  logic rst_ni,
  sbsr_if.sink   light_i,
  sbsr_if.sink   cfg_i,
  sbsr_if.source rect_o
);
  import sbsr_pkg::*;

  logic [63:0] row_q [4];
  logic [47:0] cam_q;
  logic [63:0] view_q;
  view_t       view;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) row_q[r] <= '0;
      cam_q  <= '0;
      view_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        REG_ROW0: row_q[0] <= cfg_i.data.wdata;
        REG_ROW1: row_q[1] <= cfg_i.data.wdata;
        REG_ROW2: row_q[2] <= cfg_i.data.wdata;
        REG_ROW3: row_q[3] <= cfg_i.data.wdata;
        REG_CAM:  cam_q    <= cfg_i.data.wdata[47:0];
        REG_VIEW: view_q   <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  assign view.vx = view_q[13:0];
  assign view.vy = view_q[29:16];
  assign view.vw = view_q[45:32];
  assign view.vh = view_q[61:48];

  logic f_valid, f_ready, q_valid, q_ready;
  job_t f_job, q_job;

  sbsr_front u_front (
    .clk_i, .rst_ni,
    .cam_i       (cam_q),
    .in_valid_i  (light_i.valid),
    .in_ready_o  (light_i.ready),
    .lx_i        (light_i.data.light_x),
    .ly_i        (light_i.data.light_y),
    .lz_i        (light_i.data.light_z),
    .rad_i       (light_i.data.radius),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready),
    .job_o       (f_job)
  );

  sbsr_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_job),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_job)
  );

  sbsr_back u_back (
    .clk_i, .rst_ni,
    .row_i       (row_q),
    .view_i      (view),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .out_valid_o (rect_o.valid),
    .out_ready_i (rect_o.ready),
    .rect_x_o    (rect_o.data.rect_x),
    .rect_y_o    (rect_o.data.rect_y),
    .rect_w_o    (rect_o.data.rect_w),
    .rect_h_o    (rect_o.data.rect_h),
    .full_o      (rect_o.data.full_view)
  );
endmodule

/* dv/sphere_box_scissor_rect_tb.sv */
// ----------------------------------------------------------------------------
// sphere_box_scissor_rect_tb: light scissor rectangle testbench
// Writes view-projection, camera and viewport settings, sends lights and checks
// every rectangle against a hand-typed one or a fixed-point prediction of the
// bounding box projection, under several sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module sphere_box_scissor_rect_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbsr_pkg::*;
  import sbsr_chan_pkg::*;

  localparam int DRAIN_CYCLES = 64;    // classifier + 8 corners + divider, with margin
  localparam int HOLD_CYCLES  = 600;   // long receiver hold-off

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sbsr_if #(.T(light_t)) light_if ();
  sbsr_if #(.T(cfg_t))   cfg_if ();
  sbsr_if #(.T(rect_t))  rect_if ();

  sphere_box_scissor_rect dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .light_i (light_if),
    .cfg_i   (cfg_if),
    .rect_o  (rect_if)
  );

  // register copies for the predictor
  logic [63:0] m_row [4];
  logic [47:0] m_cam;
  logic [63:0] m_view;

  typedef struct {
    bit    typed;   // expected rectangle given by hand
    rect_t exp_r;
  } pend_t;

  pend_t pend_q [$];    // one per light beat sent, in order
  rect_t rect_q [$];    // rectangles still to come
  int    err_cnt = 0;

  int  tx_idle_pct = 0;
  int  rx_stall_pct = 0;
  bit  hold_req = 1'b0;

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  function automatic longint slot16(logic [63:0] w, int s);
    return longint'($signed(w[16*s +: 16]));
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // floor(num * 65536 / (2w)) saturated to [0, 65536]
  function automatic longint screen_frac(longint num, longint w);
    longint d, rem, q;
    d = 2 * w;
    q = 0;
    if (num <= 0) return 0;
    if (num >= d) return 65536;
    rem = num;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= d) begin
        rem -= d;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic rect_t scissor_of(light_t l);
    longint c[3], p[4], clip[4];
    longint r, dist2, vx, vy, vw, vh, fx, fy, minx, miny, maxx, maxy, dd;
    bit full;
    rect_t o;
    c[0] = l.light_x;
    c[1] = l.light_y;
    c[2] = l.light_z;
    r = longint'(l.radius);
    vx = m_view[13:0];
    vy = m_view[29:16];
    vw = m_view[45:32];
    vh = m_view[61:48];
    dist2 = 0;
    for (int i = 0; i < 3; i++) begin
      dd = slot16(64'(m_cam), i) - c[i];
      dist2 += dd * dd;
    end
    minx = 65536; miny = 65536; maxx = 0; maxy = 0;
    full = (dist2 <= r * r);
    for (int k = 0; k < 8 && !full; k++) begin
      for (int i = 0; i < 3; i++)
        p[i] = sat16(((k >> i) & 1) ? c[i] + r : c[i] - r);
      p[3] = 256;
      for (int row = 0; row < 4; row++) begin
        clip[row] = 0;
        for (int i = 0; i < 4; i++) clip[row] += slot16(m_row[row], i) * p[i];
      end
      if (clip[3] <= 0) begin
        full = 1'b1;
      end else begin
        fx = screen_frac(clip[3] - clip[0], clip[3]);
        fy = screen_frac(clip[1] + clip[3], clip[3]);
        if (fx < minx) minx = fx;
        if (fx > maxx) maxx = fx;
        if (fy < miny) miny = fy;
        if (fy > maxy) maxy = fy;
      end
    end
    if (full) begin
      o = '{rect_x: 15'(vx), rect_y: 15'(vy), rect_w: 14'(vw), rect_h: 14'(vh),
            full_view: 1'b1};
    end else begin
      o.rect_x = 15'(vx + ((vw * minx) >> 16));
      o.rect_y = 15'(vy + ((vh * miny) >> 16));
      o.rect_w = 14'((vw * (maxx - minx)) >> 16);
      o.rect_h = 14'((vh * (maxy - miny)) >> 16);
      o.full_view = 1'b0;
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat monitor: a light beat turns into an expected rectangle, a rectangle
  // beat is checked against the oldest one. Config is stable while lights run.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pend_t pe;
    rect_t got, want;
    if (rst_ni && light_if.valid && light_if.ready) begin
      pe = pend_q.pop_front();
      rect_q.insert(rect_q.size(), pe.typed ? pe.exp_r : scissor_of(light_if.data));
    end
    if (rst_ni && rect_if.valid && rect_if.ready) begin
      got = rect_if.data;
      if (rect_q.size() == 0) begin
        report("unexpected rect", got, 0);
      end else begin
        want = rect_q.pop_front();
        if (got.rect_x != want.rect_x) report("rect_x", got.rect_x, want.rect_x);
        if (got.rect_y != want.rect_y) report("rect_y", got.rect_y, want.rect_y);
        if (got.rect_w != want.rect_w) report("rect_w", got.rect_w, want.rect_w);
        if (got.rect_h != want.rect_h) report("rect_h", got.rect_h, want.rect_h);
        if (got.full_view != want.full_view)
          report("full_view", got.full_view, want.full_view);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    int hold_cnt;
    bit hold_seen;
    hold_cnt = 0;
    hold_seen = 1'b0;
    rect_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      // one hold-off per request, however long the request stays up
      if (hold_req && !hold_seen) begin
        hold_cnt = HOLD_CYCLES;
        hold_seen = 1'b1;
      end
      if (!hold_req) hold_seen = 1'b0;
      if (hold_cnt > 0) begin
        hold_cnt--;
        rect_if.ready <= 1'b0;
      end else begin
        rect_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Timeout
  initial begin
    #20ms;
    $display("FAIL sphere_box_scissor_rect");
    $finish;
  end

  task automatic cfg_write(reg_idx_e idx, logic [63:0] val);
    cfg_if.data <= '{index: idx, wdata: val};
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3: m_row[idx] = val;
      REG_CAM: m_cam = val[47:0];
      REG_VIEW: m_view = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Sender: random gap ahead of a beat, then hold it until taken.
  task automatic send_light(light_t l, bit typed, rect_t e);
    while ($urandom_range(99) < tx_idle_pct) begin
      light_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pend_q.insert(pend_q.size(), '{typed: typed, exp_r: e});
    light_if.data <= l;
    light_if.valid <= 1'b1;
    do @(posedge clk_i); while (!light_if.ready);
  endtask

  // wait for every rectangle, then let the engine settle before a config write
  task automatic drain();
    light_if.valid <= 1'b0;
    while (rect_q.size() != 0 || pend_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  // kind 0: w has a positive constant term and small other coefficients; 1: fully random; 2: extremes
  task automatic load_config(int kind);
    logic [63:0] v;
    for (int i = 0; i < 6; i++) begin
      v = {$urandom, $urandom};
      if (kind == 0 && i == REG_ROW3)
        v = {16'($urandom_range(16'h0400, 16'h3000)),
             16'($signed(8'($urandom))), 16'($signed(8'($urandom))),
             16'($signed(8'($urandom)))};
      if (kind == 0 && i == REG_ROW2) v = '0;
      if (kind == 2) begin
        case (i)
          REG_ROW0: v = {4{16'h8000}};
          REG_ROW1: v = {4{16'h7FFF}};
          REG_ROW2: v = 64'hFFFF_FFFF_FFFF_FFFF;
          REG_ROW3: v = {16'h7FFF, 48'h0};
          REG_CAM:  v = 64'h0000_8000_8000_8000;
          default:  v = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
      end
      cfg_write(reg_idx_e'(i), v);
    end
  endtask

  typedef struct {
    int     stage;   // 0: reset config, 1: identity-like config
    light_t l;
    bit     typed;
    rect_t  e;
  } dir_row_t;

  localparam rect_t ZERO_FULL = '{rect_x: 15'd0, rect_y: 15'd0, rect_w: 14'd0,
                                  rect_h: 14'd0, full_view: 1'b1};
  localparam rect_t VIEW_FULL = '{rect_x: 15'h3FFF, rect_y: 15'h3FFF,
                                  rect_w: 14'h3FFF, rect_h: 14'h3FFF, full_view: 1'b1};

  dir_row_t dir_tab [] = '{
    // zero matrix after reset: every light comes out full view, empty viewport
    '{0, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF}, 1, ZERO_FULL},
    '{0, '{-16'sh8000, -16'sh8000, -16'sh8000, 16'h0000}, 1, ZERO_FULL},
    '{0, '{16'sh0000, 16'sh0000, 16'sh0000, 16'h0000}, 1, ZERO_FULL},
    '{0, '{16'sh0001, 16'sh0000, 16'sh0000, 16'h0000}, 1, ZERO_FULL},
    '{0, '{-16'sh0100, 16'sh0200, 16'sh5555, 16'hAAAA}, 1, ZERO_FULL},
    // identity-like matrix, camera at (0,0,-16384), full 0x3FFF viewport
    '{1, '{16'sh0000, 16'sh0000, -16'sh4000, 16'h0000}, 1, VIEW_FULL},
    '{1, '{16'sh0000, 16'sh0000, 16'sh0000, 16'h4000}, 1, VIEW_FULL},
    '{1, '{16'sh0000, 16'sh0000, 16'sh0000, 16'h0100}, 0, ZERO_FULL},
    '{1, '{16'sh0080, -16'sh0080, 16'sh1000, 16'h0040}, 0, ZERO_FULL},
    '{1, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF}, 0, ZERO_FULL},
    '{1, '{-16'sh8000, -16'sh8000, -16'sh8000, 16'h0001}, 0, ZERO_FULL},
    '{1, '{16'sh7F00, -16'sh7F00, 16'sh0000, 16'h0200}, 0, ZERO_FULL},
    '{1, '{-16'sh2000, 16'sh2000, 16'sh2000, 16'h0000}, 0, ZERO_FULL},
    '{1, '{16'sh0000, 16'sh0000, 16'sh7FFF, 16'h7FFF}, 0, ZERO_FULL}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    light_t l;
    int stage, kind, n;
    int tx_pct [4];
    int rx_pct [4];

    tx_pct = '{0, 72, 0, 27};
    rx_pct = '{0, 0, 72, 27};
    light_if.valid <= 1'b0;
    light_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    for (int i = 0; i < 4; i++) m_row[i] = '0;
    m_cam = '0;
    m_view = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    stage = 0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].stage != stage) begin
        drain();
        cfg_write(REG_ROW0, {48'h0, 16'h1000});
        cfg_write(REG_ROW1, {32'h0, 16'h1000, 16'h0});
        cfg_write(REG_ROW2, '0);
        cfg_write(REG_ROW3, {16'h1000, 48'h0});
        cfg_write(REG_CAM, {16'hC000, 32'h0});
        cfg_write(REG_VIEW, 64'hFFFF_FFFF_FFFF_FFFF);
        stage = dir_tab[i].stage;
      end
      send_light(dir_tab[i].l, dir_tab[i].typed, dir_tab[i].e);
    end
    drain();

    // random phases: eight of 200 lights each, idling pattern cycles through
    for (int ph = 0; ph < 8; ph++) begin
      tx_idle_pct = tx_pct[ph % 4];
      rx_stall_pct = rx_pct[ph % 4];
      kind = (ph == 5) ? 2 : ((ph % 3 == 2) ? 1 : 0);
      load_config(kind);
      for (int i = 0; i < 200; i++) begin
        if (ph == 0 && i == 20) hold_req <= 1'b1;   // receiver goes quiet, input backs up
        if (ph == 0 && i == 22) hold_req <= 1'b0;
        n = $urandom_range(99);
        if (n < 10) begin
          l = {$urandom, $urandom};                  // anything at all
        end else if (n < 20) begin
          // centre near the camera: inside, on, or just outside the sphere
          l.light_x = 16'(slot16(64'(m_cam), 0) + $signed(8'($urandom)));
          l.light_y = 16'(slot16(64'(m_cam), 1) + $signed(8'($urandom)));
          l.light_z = 16'(slot16(64'(m_cam), 2) + $signed(8'($urandom)));
          l.radius = 16'($urandom_range(0, 16'h0300));
        end else begin
          l.light_x = rnd16();
          l.light_y = rnd16();
          l.light_z = rnd16();
          l.radius = 16'($urandom_range(0, 16'h0800));
        end
        send_light(l, 1'b0, ZERO_FULL);
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("PASS sphere_box_scissor_rect");
    end else begin
      $display("FAIL sphere_box_scissor_rect");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/sbsr_pkg.sv
hw/rtl/sbsr_if.sv
hw/rtl/sbsr_light_in_t.sv
hw/rtl/sbsr_front.sv
hw/rtl/sbsr_fifo.sv
hw/rtl/sbsr_back.sv
hw/rtl/sphere_box_scissor_rect.sv
dv/sphere_box_scissor_rect_tb.sv
